// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions with a synchronous reset guard.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/stns_pkg.sv =====
// ---------------------------------------------------------------------------
// Slot table package
// Word types, field widths, codes and defaults shared by the slot table.
// ---------------------------------------------------------------------------
package stns_pkg;

   localparam int POS_W         = 10;
   localparam int VAL_W         = 31;
   localparam int SUM_W         = 64;
   localparam int SLOTS_DEFAULT = 1024;
   localparam int ADDR_W_DEFAULT = $clog2(SLOTS_DEFAULT) + 1;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic        [VAL_W-1:0] left_value;
      logic        [VAL_W-1:0] right_value;
      logic signed [SUM_W-1:0] pair_sum;
      logic                    status;
   } rsp_word_type;

   typedef enum logic [1:0] {
      MAC_IDLE   = 2'd0,
      MAC_LR     = 2'd1,
      MAC_LS     = 2'd2,
      MAC_COMMIT = 2'd3
   } mac_op_type;

   typedef struct packed {
      mac_op_type op;
      logic       is_remove;
   } mac_ctrl_type;

endpackage

// ===== sv/stns_mem.sv =====
// ---------------------------------------------------------------------------
// Slot table tree memory
// Max-tree node store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module stns_mem #(
   parameter int ADDR_W = stns_pkg::ADDR_W_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [stns_pkg::VAL_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [stns_pkg::VAL_W-1:0] rd_data
);

   localparam int Depth = 2 ** ADDR_W;

   logic [stns_pkg::VAL_W-1:0] mem [0:Depth-1];
   logic [stns_pkg::VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/stns_mac.sv =====
// ---------------------------------------------------------------------------
// Slot table multiply-accumulate
// One shared multiplier forms the neighbour products in two steps and
// folds them into the running pair sum.
// ---------------------------------------------------------------------------
module stns_mac (
   input  logic                       clock,
   input  logic                       reset,
   input  stns_pkg::mac_ctrl_type     ctrl,
   input  logic [stns_pkg::VAL_W-1:0] left_value,
   input  logic [stns_pkg::VAL_W-1:0] right_value,
   input  logic [stns_pkg::VAL_W-1:0] operand,
   output logic [stns_pkg::SUM_W-1:0] sum
);

   localparam int ProdW = 2 * stns_pkg::VAL_W + 1;

   logic [stns_pkg::VAL_W:0]   mul_a;
   logic [stns_pkg::VAL_W-1:0] mul_b;
   logic [ProdW-1:0]           mul_p;
   logic [ProdW-1:0]           prod_ff, prod_in;
   logic [stns_pkg::SUM_W-1:0] prod_ext;
   logic [stns_pkg::SUM_W-1:0] acc_ff, acc_in;
   logic [stns_pkg::SUM_W-1:0] sum_ff, sum_in;

   always_comb begin
      if (ctrl.op == stns_pkg::MAC_LR) begin
         mul_a = {1'b0, left_value};
         mul_b = right_value;
      end else begin
         mul_a = {1'b0, left_value} + {1'b0, right_value};
         mul_b = operand;
      end
      mul_p = {{stns_pkg::VAL_W{1'b0}}, mul_a} * {{(stns_pkg::VAL_W + 1){1'b0}}, mul_b};
   end

   assign prod_ext = {{(stns_pkg::SUM_W - ProdW){1'b0}}, prod_ff};

   // Insert: sum - left*right + (left+right)*value; remove has the signs swapped.
   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      sum_in  = sum_ff;
      case (ctrl.op)
         stns_pkg::MAC_LR: begin
            prod_in = mul_p;
         end
         stns_pkg::MAC_LS: begin
            prod_in = mul_p;
            acc_in  = ctrl.is_remove ? sum_ff + prod_ext : sum_ff - prod_ext;
         end
         stns_pkg::MAC_COMMIT: begin
            sum_in = ctrl.is_remove ? acc_ff - prod_ext : acc_ff + prod_ext;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign sum = sum_ff;

endmodule

// ===== sv/slot_table_neighbor_pair_sum.sv =====
// ---------------------------------------------------------------------------
// Slot table with neighbour pair sum
// A word that is taken goes through a leaf read, two tree walks, two multiplier steps and
// the update walk; the walks visit one node per cycle through the tree memory. The
// multiplier steps and the update walk are skipped when the request does not apply, and
// out-of-range words go straight to the result. start is taken again in the strobe cycle,
// and the receiver never stalls. After reset the tree is swept to zero with busy high.
// ---------------------------------------------------------------------------
module slot_table_neighbor_pair_sum #(
   parameter int SLOTS = stns_pkg::SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  stns_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output stns_pkg::rsp_word_type rsp_word
);

   localparam int Levels  = $clog2(SLOTS);
   localparam int AddrW   = Levels + 1;
   localparam int PosExtW = Levels + stns_pkg::POS_W;

   localparam logic [PosExtW-1:0] SlotsExt = PosExtW'(SLOTS);
   localparam logic [AddrW-1:0]   NodeRoot = AddrW'(1);

   localparam logic DIR_LEFT  = 1'b0;
   localparam logic DIR_RIGHT = 1'b1;

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b0000000001,
      ST_IDLE   = 10'b0000000010,
      ST_LEAF   = 10'b0000000100,
      ST_UP     = 10'b0000001000,
      ST_DOWN   = 10'b0000010000,
      ST_MUL_LR = 10'b0000100000,
      ST_MUL_LS = 10'b0001000000,
      ST_WLEAF  = 10'b0010000000,
      ST_UPD    = 10'b0100000000,
      ST_DONE   = 10'b1000000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [AddrW-1:0]           clr_ff, clr_in;
   stns_pkg::req_word_type     req_ff, req_in;
   logic [AddrW-1:0]           node_ff, node_in;
   logic [stns_pkg::VAL_W-1:0] nval_ff, nval_in;
   logic                       dir_ff, dir_in;
   logic [stns_pkg::VAL_W-1:0] cur_ff, cur_in;
   logic [stns_pkg::VAL_W-1:0] left_ff, left_in;
   logic [stns_pkg::VAL_W-1:0] right_ff, right_in;
   logic                       act_ff, act_in;
   stns_pkg::rsp_word_type     rsp_ff, rsp_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;

   logic [PosExtW-1:0]         pos_new_ext, pos_req_ext;
   logic                       in_range_new;
   logic [AddrW-1:0]           leaf_new, leaf_req;
   logic                       apply_req;
   logic                       search_end;
   logic [stns_pkg::VAL_W-1:0] search_val;
   logic [AddrW-1:0]           upd_parent;
   logic [stns_pkg::VAL_W-1:0] upd_max;

   logic                       wr_en;
   logic [AddrW-1:0]           wr_addr;
   logic [stns_pkg::VAL_W-1:0] wr_data;
   logic [AddrW-1:0]           rd_addr;
   logic [stns_pkg::VAL_W-1:0] rd_data;

   stns_pkg::mac_ctrl_type     mac_ctrl;
   logic [stns_pkg::SUM_W-1:0] mac_sum;

   assign pos_new_ext  = {{Levels{1'b0}}, req_word.position};
   assign pos_req_ext  = {{Levels{1'b0}}, req_ff.position};
   assign in_range_new = (pos_new_ext < SlotsExt);
   assign leaf_new     = {1'b1, pos_new_ext[Levels-1:0]};
   assign leaf_req     = {1'b1, pos_req_ext[Levels-1:0]};

   assign apply_req = (req_ff.req_type == stns_pkg::REQ_REMOVE) ? (cur_ff != '0) :
                      ((cur_ff == '0) && (req_ff.value != '0));

   assign upd_parent = {1'b0, node_ff[AddrW-1:1]};
   assign upd_max    = (rd_data > nval_ff) ? rd_data : nval_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      req_in        = req_ff;
      node_in       = node_ff;
      nval_in       = nval_ff;
      dir_in        = dir_ff;
      cur_in        = cur_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      act_in        = act_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      search_end    = 1'b0;
      search_val    = '0;
      wr_en         = 1'b0;
      wr_addr       = clr_ff;
      wr_data       = '0;
      mac_ctrl.op        = stns_pkg::MAC_IDLE;
      mac_ctrl.is_remove = (req_ff.req_type == stns_pkg::REQ_REMOVE);

      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + AddrW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in = req_word;
               if (in_range_new) begin
                  node_in  = leaf_new;
                  state_in = ST_LEAF;
               end else begin
                  left_in  = '0;
                  right_in = '0;
                  act_in   = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_LEAF: begin
            cur_in   = rd_data;
            dir_in   = DIR_LEFT;
            state_in = ST_UP;
         end
         ST_UP: begin
            // A sibling on the search side holds the nearest neighbour if it is non-empty.
            if (node_ff == NodeRoot) begin
               search_end = 1'b1;
            end else if ((node_ff[0] != dir_ff) && (rd_data != '0)) begin
               node_in  = {node_ff[AddrW-1:1], ~node_ff[0]};
               nval_in  = rd_data;
               state_in = ST_DOWN;
            end else begin
               node_in = {1'b0, node_ff[AddrW-1:1]};
            end
         end
         ST_DOWN: begin
            // The child nearer the position is read; if empty, the other one
            // carries the parent's maximum, so its value is already known.
            if (node_ff[AddrW-1]) begin
               search_end = 1'b1;
               search_val = nval_ff;
            end else if (rd_data != '0) begin
               node_in = {node_ff[AddrW-2:0], ~dir_ff};
               nval_in = rd_data;
            end else begin
               node_in = {node_ff[AddrW-2:0], dir_ff};
            end
         end
         ST_MUL_LR: begin
            mac_ctrl.op = stns_pkg::MAC_LR;
            state_in    = ST_MUL_LS;
         end
         ST_MUL_LS: begin
            mac_ctrl.op = stns_pkg::MAC_LS;
            state_in    = ST_WLEAF;
         end
         ST_WLEAF: begin
            mac_ctrl.op = stns_pkg::MAC_COMMIT;
            wr_en       = 1'b1;
            wr_addr     = leaf_req;
            wr_data     = (req_ff.req_type == stns_pkg::REQ_REMOVE) ? '0 : req_ff.value;
            node_in     = leaf_req;
            nval_in     = wr_data;
            state_in    = ST_UPD;
         end
         ST_UPD: begin
            wr_en    = 1'b1;
            wr_addr  = upd_parent;
            wr_data  = upd_max;
            node_in  = upd_parent;
            nval_in  = upd_max;
            state_in = (upd_parent == NodeRoot) ? ST_DONE : ST_UPD;
         end
         ST_DONE: begin
            rsp_in.left_value  = left_ff;
            rsp_in.right_value = right_ff;
            rsp_in.pair_sum    = mac_sum;
            rsp_in.status      = act_ff ? stns_pkg::STATUS_DONE : stns_pkg::STATUS_IGNORED;
            rsp_strobe_in      = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (search_end) begin
         if (dir_ff == DIR_LEFT) begin
            left_in  = search_val;
            dir_in   = DIR_RIGHT;
            node_in  = leaf_req;
            state_in = ST_UP;
         end else begin
            right_in = search_val;
            act_in   = apply_req;
            state_in = apply_req ? ST_MUL_LR : ST_DONE;
         end
      end

      // The read for the next cycle follows from where the walk goes next.
      if (state_in == ST_DOWN) begin
         rd_addr = {node_in[AddrW-2:0], ~dir_in};
      end else if (state_in == ST_LEAF) begin
         rd_addr = node_in;
      end else begin
         rd_addr = {node_in[AddrW-1:1], ~node_in[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         dir_ff        <= DIR_LEFT;
         act_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         dir_ff        <= dir_in;
         act_ff        <= act_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff   <= req_in;
      node_ff  <= node_in;
      nval_ff  <= nval_in;
      cur_ff   <= cur_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      rsp_ff   <= rsp_in;
   end

   stns_mem #(
      .ADDR_W (AddrW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stns_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (mac_ctrl),
      .left_value  (left_ff),
      .right_value (right_ff),
      .operand     ((req_ff.req_type == stns_pkg::REQ_REMOVE) ? cur_ff : req_ff.value),
      .sum         (mac_sum)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== sv/stns_checker.sv =====
// ---------------------------------------------------------------------------
// Slot table port checker
// Watches the top-level ports for sequencing slips between requests and
// result strobes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stns_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // Every accepted word has the block busy in the cycle after it is taken.
   `ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy)

   // A result is only shown once the block is free again.
   `ASSERT_NOW(a_strobe_when_idle, clock, reset, rsp_strobe, !busy)

   // One word in gives one strobe, never two back to back.
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)

   // A strobe always closes a stretch of work.
   `ASSERT_NOW(a_strobe_after_work, clock, reset, rsp_strobe, $past(busy))

endmodule

bind slot_table_neighbor_pair_sum stns_checker u_checker (.*);
